// File: design/ibd_pkg.sv
// Shared types, constants and helpers for the integer to base digits converter.
package ibd_pkg;

  // Field and register widths fixed by the interface.
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 2'd1;

  // Radix limits and defaults.
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] DECIMAL     = 5'd10;

  // ASCII codes.
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
  // 'A' minus ten, so that digit ten maps onto 'A'.
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 7'd55;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

  // Converter sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  // Control bundle from the sequencer to the digit row.
  typedef struct packed {
    logic clr;
    logic conv;
    logic feed;
    logic bit_in;
    logic shift;
  } row_ctrl_t;

  // Map one digit value onto its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// File: design/ibd_stream_if.sv
// Valid/ready stream interfaces for the input value and the output characters.
interface ibd_value_if import ibd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ibd_char_if import ibd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

// File: design/integer_to_base_digits.sv
// Sequence: the conversion phase feeds the value bit-serially into the digit cell row, the
// alignment phase shifts the leading digit up to the top cell, then the sign and digits follow;
// NCELLS equals VALUE_BITS. Only one value is in flight: the input is ready only while idle,
// after the last character is taken, so output stalls also hold off the next value.
// The rate is set by the bit-serial digit cell row.
// Reset: asynchronous, active low; radix returns to ten, signed mode off, sequencer idle.
module integer_to_base_digits import ibd_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ibd_value_if.sink             value_i,
  ibd_char_if.source            char_o
);

  localparam int NCELLS      = VALUE_BITS;
  localparam int LEN_W       = $clog2(NCELLS + 1);
  localparam int CONV_CYCLES = VALUE_BITS + NCELLS - 1;
  localparam int CNT_W       = $clog2(CONV_CYCLES + 1);
  localparam int REM_MAX     = (NCELLS + 1 > MAX_DIGITS) ? MAX_DIGITS : NCELLS + 1;
  localparam int REM_W       = $clog2(REM_MAX + 1);

  state_e               state_q, state_d;
  logic [RADIX_W-1:0]   radix_q;
  logic                 signed_q;
  logic [RADIX_W-1:0]   base_q;
  logic                 neg_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [REM_W-1:0]     rem_q;

  logic                 in_acc, out_acc, out_valid;
  logic [VALUE_BITS-1:0] v_raw, v_mag;
  logic                 v_neg;
  logic [RADIX_W-1:0]   base_sel;
  logic                 conv_done, align_done;
  logic [CNT_W:0]       align_pos;
  logic [LEN_W:0]       total_chars;
  logic [REM_W-1:0]     rem_load;

  row_ctrl_t            row_ctrl;
  logic [DIGIT_W-1:0]   top_digit;
  logic [LEN_W-1:0]     row_len;

  // Request handshakes.
  assign in_acc  = value_i.valid & value_i.ready;
  assign out_acc = out_valid & char_o.ready;

  // Magnitude and base of a new request.
  always_comb begin
    v_raw = VALUE_BITS'(value_i.value);
    v_neg = signed_q & v_raw[VALUE_BITS-1];
    v_mag = v_neg ? (~v_raw + 1'b1) : v_raw;
    if (signed_q) begin
      base_sel = DECIMAL;
    end else if (radix_q < RADIX_MIN) begin
      base_sel = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      base_sel = RADIX_MAX;
    end else begin
      base_sel = radix_q;
    end
  end

  // Phase completion and character count.
  always_comb begin
    conv_done   = (cnt_q == CNT_W'(CONV_CYCLES - 1));
    align_pos   = (CNT_W+1)'(row_len) + (CNT_W+1)'(cnt_q);
    align_done  = (align_pos == (CNT_W+1)'(NCELLS));
    total_chars = (LEN_W+1)'(row_len) + (LEN_W+1)'(neg_q);
    if (total_chars > (LEN_W+1)'(MAX_DIGITS)) begin
      rem_load = REM_W'(MAX_DIGITS);
    end else begin
      rem_load = REM_W'(total_chars);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_d = ST_ALIGN;
      end
      ST_ALIGN: begin
        if (align_done) state_d = neg_q ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (out_acc) state_d = (rem_q == REM_W'(1)) ? ST_IDLE : ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_acc && (rem_q == REM_W'(1))) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    value_i.ready   = (state_q == ST_IDLE);
    out_valid       = (state_q == ST_SIGN) || (state_q == ST_DIGIT);
    row_ctrl.clr    = in_acc;
    row_ctrl.conv   = (state_q == ST_CONV);
    row_ctrl.feed   = (state_q == ST_CONV) && (cnt_q < CNT_W'(VALUE_BITS));
    row_ctrl.bit_in = val_q[VALUE_BITS-1];
    row_ctrl.shift  = ((state_q == ST_ALIGN) && !align_done) ||
                      ((state_q == ST_DIGIT) && out_acc);
  end

  assign char_o.valid     = out_valid;
  assign char_o.character = (state_q == ST_SIGN) ? CHAR_MINUS : digit_char(top_digit);
  assign char_o.last_char = (rem_q == REM_W'(1));

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      radix_q  <= RADIX_RESET;
      signed_q <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RADIX:  radix_q  <= cfg_data_i[RADIX_W-1:0];
          CFG_SIGNED: signed_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        cnt_q <= '0;
      end else if (state_q == ST_CONV) begin
        cnt_q <= conv_done ? '0 : cnt_q + 1'b1;
      end else if ((state_q == ST_ALIGN) && !align_done) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if ((state_q == ST_ALIGN) && align_done) begin
        rem_q <= rem_load;
      end else if (out_acc) begin
        rem_q <= rem_q - 1'b1;
      end
    end
  end

  // Payload registers: the value shifts out most significant bit first.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q  <= v_mag;
      base_q <= base_sel;
      neg_q  <= v_neg;
    end else if (state_q == ST_CONV) begin
      val_q <= {val_q[VALUE_BITS-2:0], 1'b0};
    end
  end

  ibd_digit_row #(
    .NCELLS (NCELLS)
  ) u_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (row_ctrl),
    .base_i      (base_q),
    .top_digit_o (top_digit),
    .len_o       (row_len)
  );

  // A new request always starts a fresh conversion count.
  a_start_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CONV) && (cnt_q == '0))
    else $error("conversion did not start after an input request");

  // The last character of a run returns the block to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && char_o.last_char) |=> (state_q == ST_IDLE))
    else $error("block not idle after the last character");

  // Every emitted digit lies below the base in use.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> ({1'b0, top_digit} < base_q))
    else $error("emitted digit not below the base");

  // The digit count stays within the cell row.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALIGN) |-> ((row_len != '0) && (row_len <= LEN_W'(NCELLS))))
    else $error("digit count out of range");

  // A minus sign is only sent for a negative value.
  a_sign_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN) |-> neg_q)
    else $error("minus sign for a non-negative value");

endmodule

// File: design/ibd_digit_row.sv
// Row of radix digit cells: doubles-and-adds one input bit per cycle, skewed by cell.
module ibd_digit_row import ibd_pkg::*; #(
  parameter int NCELLS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  row_ctrl_t                       ctrl_i,
  input  logic [RADIX_W-1:0]              base_i,
  output logic [DIGIT_W-1:0]              top_digit_o,
  output logic [$clog2(NCELLS+1)-1:0]     len_o
);

  localparam int LEN_W = $clog2(NCELLS + 1);
  localparam int IDX_W = $clog2(NCELLS);

  // Each input bit reaches the cells in order, cell 0 first; enable and carry travel one cell per cycle.
  logic [DIGIT_W-1:0] dig_q [NCELLS];
  logic [NCELLS-1:0]  en_q;
  logic [NCELLS-1:0]  cy_q;
  logic [LEN_W-1:0]   len_q;

  logic [NCELLS-1:0]  cell_en;
  logic [NCELLS-1:0]  cell_cout;
  logic [DIGIT_W-1:0] cell_d [NCELLS];

  // Per cell: t = 2*d + carry_in, reduced once by the base.
  always_comb begin
    logic [RADIX_W-1:0] t;
    logic               cin;
    for (int i = 0; i < NCELLS; i++) begin
      cell_en[i] = (i == 0) ? ctrl_i.feed : en_q[i];
      cin        = (i == 0) ? ctrl_i.bit_in : cy_q[i];
      t          = {dig_q[i], 1'b0} + RADIX_W'(cin);
      cell_cout[i] = (t >= base_i);
      cell_d[i]    = cell_cout[i] ? DIGIT_W'(t - base_i) : DIGIT_W'(t);
    end
  end

  // Enable line, carries and the significant digit count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= '0;
      cy_q  <= '0;
      len_q <= LEN_W'(1);
    end else if (ctrl_i.clr) begin
      en_q  <= '0;
      cy_q  <= '0;
      len_q <= LEN_W'(1);
    end else if (ctrl_i.conv) begin
      en_q <= {cell_en[NCELLS-2:0], 1'b0};
      cy_q <= {cell_cout[NCELLS-2:0] & cell_en[NCELLS-2:0], 1'b0};
      // A carry reaching the first unused cell adds one significant digit.
      if ((len_q < LEN_W'(NCELLS)) && cy_q[len_q[IDX_W-1:0]]) begin
        len_q <= len_q + 1'b1;
      end
    end
  end

  // Digit storage: updated by the cells while converting, shifted up while aligning and emitting.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      for (int i = 0; i < NCELLS; i++) begin
        dig_q[i] <= '0;
      end
    end else if (ctrl_i.conv) begin
      for (int i = 0; i < NCELLS; i++) begin
        if (cell_en[i]) begin
          dig_q[i] <= cell_d[i];
        end
      end
    end else if (ctrl_i.shift) begin
      dig_q[0] <= '0;
      for (int i = 1; i < NCELLS; i++) begin
        dig_q[i] <= dig_q[i-1];
      end
    end
  end

  assign top_digit_o = dig_q[NCELLS-1];
  assign len_o       = len_q;

endmodule

// File: bench/tb_integer_to_base_digits.sv
// Testbench for the integer to base digits converter: directed and random values.
`timescale 1ns / 100ps

module tb_integer_to_base_digits;
  import ibd_pkg::*;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // ASCII codes used by the predictor.
  localparam logic [CHAR_W-1:0] ASCII_DIGIT_0 = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;
  localparam logic [CHAR_W-1:0] ASCII_DASH    = 7'd45;

  localparam int MAX_CHARS  = 32;
  localparam int STALL_LEN  = 400;
  localparam int TAIL_WAIT  = 140;

  // One expected output character.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } digit_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ibd_value_if value_bus ();
  ibd_char_if  char_bus ();

  integer_to_base_digits u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .value_i    (value_bus),
    .char_o     (char_bus)
  );

  // Predictor copy of the configuration registers.
  logic [RADIX_W-1:0] model_radix;
  logic               model_signed;

  // Characters still owed by the block, oldest first.
  digit_t digit_q[$];

  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, plus a long hold when one is requested.
  initial begin
    char_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        char_bus.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        char_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compute the characters of one value under the current settings.
  function automatic void predict_digits(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] rem;
    logic [RADIX_W-1:0] base;
    logic [CHAR_W-1:0]  rev[$];
    logic               negative;
    digit_t             item;
    int                 count;
    mag      = v;
    negative = 1'b0;
    if (model_signed) begin
      base = DECIMAL;
      if (v[VALUE_W-1]) begin
        // The most negative value wraps to itself, which reads as 2^31 unsigned.
        negative = 1'b1;
        mag      = -v;
      end
    end else begin
      base = model_radix;
      if (base < RADIX_MIN) base = RADIX_MIN;
      if (base > RADIX_MAX) base = RADIX_MAX;
    end
    // Digits come out least significant first; zero still yields one digit.
    do begin
      rem = mag % base;
      if (rem < 10) begin
        rev.push_back(ASCII_DIGIT_0 + CHAR_W'(rem));
      end else begin
        rev.push_back(ASCII_UPPER_A + CHAR_W'(rem - 10));
      end
      mag = mag / base;
    end while (mag != 0);
    if (negative) rev.push_back(ASCII_DASH);
    count = (rev.size() > MAX_CHARS) ? MAX_CHARS : rev.size();
    for (int k = 0; k < count; k++) begin
      item.character = rev[rev.size() - 1 - k];
      item.last_char = (k == count - 1);
      digit_q.push_back(item);
    end
  endfunction

  // Compare each accepted character with the oldest expectation.
  always @(posedge clk_i) begin : check_chars
    digit_t want;
    if (rst_ni && char_bus.valid && char_bus.ready) begin
      if (digit_q.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("ERROR: unexpected character %0d last %0b at %0t",
                   char_bus.character, char_bus.last_char, $realtime);
        end
      end else begin
        want = digit_q.pop_front();
        if (char_bus.character !== want.character || char_bus.last_char !== want.last_char) begin
          error_count++;
          if (error_count <= 10) begin
            $display("ERROR: character exp %0d got %0d, last exp %0b got %0b at %0t",
                     want.character, char_bus.character, want.last_char,
                     char_bus.last_char, $realtime);
          end
        end
      end
    end
  end

  // Offer one value after a random gap and record its characters once taken.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      value_bus.valid <= 1'b0;
      value_bus.value <= $urandom;
    end
    @(negedge clk_i);
    value_bus.valid <= 1'b1;
    value_bus.value <= v;
    do @(posedge clk_i); while (!value_bus.ready);
    predict_digits(v);
  endtask

  // Stop offering and wait until every owed character has arrived.
  task automatic drain_results();
    @(negedge clk_i);
    value_bus.valid <= 1'b0;
    while (digit_q.size() != 0) @(posedge clk_i);
  endtask

  // One register write through the configuration port.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      CFG_RADIX:  model_radix = data;
      CFG_SIGNED: model_signed = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Bring the block to idle, then set both registers.
  task automatic set_config(input logic [CFG_DATA_W-1:0] radix, input logic [CFG_DATA_W-1:0] sgn);
    drain_results();
    write_reg(CFG_RADIX, radix);
    write_reg(CFG_SIGNED, sgn);
  endtask

  // Random value with a spread of magnitudes and the usual corner values.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned sel;
    logic [VALUE_W-1:0] v;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      v = $urandom;
    end else if (sel < 7) begin
      v = $urandom >> $urandom_range(1, 31);
    end else if (sel == 7) begin
      v = $urandom_range(0, 40);
    end else if (sel == 8) begin
      case ($urandom_range(0, 3))
        0: v = '0;
        1: v = '1;
        2: v = {1'b1, {(VALUE_W-1){1'b0}}};
        default: v = {1'b0, {(VALUE_W-1){1'b1}}};
      endcase
    end else begin
      v = -VALUE_W'($urandom_range(1, 1000));
    end
    return v;
  endfunction

  // Reset settings: unsigned decimal.
  task automatic test_reset_defaults();
    send_value('0);
    send_value('1);
    send_value(32'd1234567890);
  endtask

  // Radix extremes, every hex digit, and clamping of out-of-range radix values.
  task automatic test_radix_range();
    set_config(5'd2, 5'd0);
    send_value('1);
    send_value('0);
    send_value(32'd1);
    set_config(5'd16, 5'd0);
    send_value(32'hFEDCBA98);
    send_value(32'h01234567);
    set_config(5'd0, 5'd0);
    send_value(32'd6);
    set_config(5'd1, 5'd0);
    send_value(32'd6);
    set_config(5'd17, 5'd0);
    send_value(32'hABCDEF12);
    set_config(5'd31, 5'd0);
    send_value(32'hABCDEF12);
    set_config(5'd3, 5'd0);
    send_value('1);
    set_config(5'd7, 5'd0);
    send_value(32'h12345678);
  endtask

  // Writes to undecoded indexes must leave both registers alone.
  task automatic test_unused_index();
    set_config(5'd8, 5'd0);
    write_reg(CFG_SPARE_A, 5'd31);
    write_reg(CFG_SPARE_B, 5'd1);
    send_value(32'hDEADBEEF);
  endtask

  // Signed decimal ignores the radix; includes the most negative value.
  task automatic test_signed_decimal();
    set_config(5'd2, 5'd1);
    send_value('0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(-32'd10);
    send_value('1);
    send_value(32'h80000000);
    send_value(32'h7FFFFFFF);
    send_value(-32'd1234567890);
  endtask

  // Long output hold while values keep coming, so the input stalls.
  task automatic test_output_stall();
    set_config(5'd2, 5'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_left = STALL_LEN;
    for (int i = 0; i < 6; i++) send_value($urandom);
    drain_results();
  endtask

  // Random values in blocks, each block under fresh random settings.
  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int b = 0; b < 4; b++) begin
      set_config(CFG_DATA_W'($urandom_range(0, 31)), CFG_DATA_W'($urandom_range(0, 31)));
      for (int i = 0; i < 12; i++) send_value(pick_value());
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_RADIX;
    cfg_data        = '0;
    value_bus.valid = 1'b0;
    value_bus.value = '0;
    model_radix     = RADIX_RESET;
    model_signed    = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 30;
    test_reset_defaults();
    test_radix_range();
    test_unused_index();
    test_signed_decimal();
    test_output_stall();
    test_random_phase(29, 88);
    test_random_phase(88, 29);
    test_random_phase(0, 0);

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (error_count == 0 && digit_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
